// ===== design/pbc_pkg.sv =====
// Package for the packet buffer cursor block.
// Holds sizes, command and origin codes, and the controller state type.
// No dependencies.
package pbc_pkg;

  localparam int unsigned Depth    = 4096;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned PtrW     = AddrW + 1;
  localparam int unsigned ArithW   = PtrW + 3;
  localparam int unsigned DataW    = 8;
  localparam int unsigned FieldW   = 14;

  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_PEEK   = 3'd1,
    CMD_NEXT   = 3'd2,
    CMD_SKIP   = 3'd3,
    CMD_PUT    = 3'd4,
    CMD_SEEK   = 3'd5,
    CMD_HIDE   = 3'd6,
    CMD_REWIND = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ORG_START   = 2'd0,
    ORG_CURSOR  = 2'd1,
    ORG_END     = 2'd2,
    ORG_INVALID = 2'd3
  } origin_e;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

endpackage

// ===== design/pbc_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module pbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/packet_buffer_cursor_top.sv =====
// Packet buffer cursor: byte store with a visible window and a cursor.
// done_o rises in the cycle after the start transfer; one command per cycle
// when not busy, set by the single RAM port (read or write) and the pointer
// update. After reset the byte store is zeroed by a clearing pass, one byte
// per cycle, with busy high; config writes are taken during it. Results
// cannot be stalled by the receiver. Depends on pbc_pkg and pbc_ram.
module packet_buffer_cursor_top
  import pbc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_we_i,
  input  logic [PtrW-1:0]          cfg_wdata_i,
  input  logic [2:0]               cmd_i,
  input  logic [DataW-1:0]         data_in_i,
  input  logic signed [FieldW-1:0] offset_i,
  input  logic [1:0]               origin_i,
  output logic                     done_o,
  output logic [DataW-1:0]         data_out_o,
  output logic                     end_hit_o,
  output logic signed [FieldW-1:0] position_o,
  output logic signed [FieldW-1:0] segment_size_o,
  output logic signed [FieldW-1:0] applied_count_o,
  output logic                     at_end_o
);

  localparam logic [PtrW-1:0] DepthPtr = PtrW'(Depth);

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [PtrW-1:0]  len_q, len_d, start_q, start_d, cur_q, cur_d, end_q, end_d;
  logic             done_q, done_d;
  logic             rd_sel_q, rd_sel_d;
  logic [DataW-1:0] dout_q, dout_d;
  logic             end_hit_q, end_hit_d;
  logic [FieldW-1:0] pos_q, pos_d, size_q, size_d, appl_q, appl_d;
  logic             at_end_q, at_end_d;

  logic             accept;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  logic signed [ArithW-1:0] off_s, st_s, cur_s, end_s, len_s, tgt, clip;
  logic [PtrW-1:0]  cur_inc;
  logic             cur_ok, inc_ok, off_nz;
  logic [PtrW-1:0]  cfg_len;
  cmd_e             cmd;
  origin_e          org;

  assign cmd    = cmd_e'(cmd_i);
  assign org    = origin_e'(origin_i);
  assign busy   = (state_q != ST_RUN);
  assign accept = start && !busy;

  assign off_s   = ArithW'(offset_i);
  assign st_s    = $signed({3'b000, start_q});
  assign cur_s   = $signed({3'b000, cur_q});
  assign end_s   = $signed({3'b000, end_q});
  assign len_s   = $signed({3'b000, len_q});
  assign cur_inc = cur_q + PtrW'(1);
  assign cur_ok  = cur_q < end_q;
  assign inc_ok  = cur_inc < end_q;
  assign off_nz  = offset_i != '0;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_len = PtrW'(1);
    end else if (cfg_wdata_i > DepthPtr) begin
      cfg_len = DepthPtr;
    end else begin
      cfg_len = cfg_wdata_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    len_d     = len_q;
    start_d   = start_q;
    cur_d     = cur_q;
    end_d     = end_q;
    done_d    = 1'b0;
    rd_sel_d  = 1'b0;
    dout_d    = '0;
    end_hit_d = 1'b0;
    appl_d    = '0;
    ram_we    = 1'b0;
    ram_addr  = cur_q[AddrW-1:0];
    ram_wdata = data_in_i;
    tgt       = '0;
    clip      = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == '1) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          done_d = 1'b1;
          case (cmd)
            CMD_GET, CMD_PEEK: begin
              if (cur_ok) begin
                rd_sel_d = 1'b1;
                if (cmd == CMD_GET) begin
                  cur_d = cur_inc;
                end
              end else begin
                end_hit_d = 1'b1;
              end
            end
            CMD_NEXT: begin
              if (cur_ok) begin
                cur_d    = cur_inc;
                ram_addr = cur_inc[AddrW-1:0];
                if (inc_ok) begin
                  rd_sel_d = 1'b1;
                end else begin
                  end_hit_d = 1'b1;
                end
              end else begin
                end_hit_d = 1'b1;
              end
            end
            CMD_SKIP: begin
              if (cur_ok) begin
                cur_d = cur_inc;
              end else begin
                end_hit_d = 1'b1;
              end
            end
            CMD_PUT: begin
              if (cur_ok) begin
                ram_we = 1'b1;
                dout_d = data_in_i;
                cur_d  = cur_inc;
              end else begin
                end_hit_d = 1'b1;
              end
            end
            CMD_SEEK: begin
              if (!off_nz) begin
                if (org == ORG_START) begin
                  cur_d = start_q;
                end else if (org == ORG_END) begin
                  cur_d = end_q;
                end
              end else begin
                case (org)
                  ORG_START:  tgt = st_s + off_s;
                  ORG_CURSOR: tgt = cur_s + off_s;
                  ORG_END:    tgt = end_s - off_s;
                  default:    tgt = cur_s;
                endcase
                clip = (tgt < 0) ? '0 : tgt;
                if (clip < st_s) begin
                  cur_d = start_q;
                end else if (clip > end_s) begin
                  cur_d = end_q;
                end else begin
                  cur_d = clip[PtrW-1:0];
                end
              end
            end
            CMD_HIDE: begin
              if (off_nz && (org == ORG_START || org == ORG_END)) begin
                tgt  = (org == ORG_START) ? (st_s + off_s) : (end_s - off_s);
                clip = (tgt < 0) ? '0 : ((tgt > len_s) ? len_s : tgt);
                cur_d = clip[PtrW-1:0];
                if (org == ORG_START) begin
                  start_d = clip[PtrW-1:0];
                  appl_d  = FieldW'(clip - st_s);
                end else begin
                  end_d  = clip[PtrW-1:0];
                  appl_d = FieldW'(end_s - clip);
                end
              end
            end
            default: begin
              start_d = '0;
              cur_d   = '0;
              end_d   = len_q;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    if (cfg_we_i) begin
      len_d   = cfg_len;
      start_d = '0;
      cur_d   = '0;
      end_d   = cfg_len;
    end
  end

  assign pos_d    = FieldW'({1'b0, cur_d}) - FieldW'({1'b0, start_d});
  assign size_d   = FieldW'({1'b0, end_d}) - FieldW'({1'b0, start_d});
  assign at_end_d = cur_d == end_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      len_q   <= DepthPtr;
      start_q <= '0;
      cur_q   <= '0;
      end_q   <= DepthPtr;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      len_q   <= len_d;
      start_q <= start_d;
      cur_q   <= cur_d;
      end_q   <= end_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_sel_q  <= rd_sel_d;
      dout_q    <= dout_d;
      end_hit_q <= end_hit_d;
      pos_q     <= pos_d;
      size_q    <= size_d;
      appl_q    <= appl_d;
      at_end_q  <= at_end_d;
    end
  end

  pbc_ram #(
    .Width(DataW),
    .Depth(Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign done_o          = done_q;
  assign data_out_o      = rd_sel_q ? ram_rdata : dout_q;
  assign end_hit_o       = end_hit_q;
  assign position_o      = pos_q;
  assign segment_size_o  = size_q;
  assign applied_count_o = appl_q;
  assign at_end_o        = at_end_q;

endmodule

// ===== dv/tb_packet_buffer_cursor_top.sv =====
// Testbench for packet_buffer_cursor_top: directed table, then random command phases
// across several lengths, each result checked against a typed row or a window/cursor
// predictor. Depends on pbc_pkg and the packet_buffer_cursor_top RTL.
`timescale 1ns / 100ps

module tb_packet_buffer_cursor_top
  import pbc_pkg::*;
();

  localparam int QuietLimit = 20000;

  typedef struct packed {
    logic [DataW-1:0]         data;
    logic                     end_hit;
    logic signed [FieldW-1:0] position;
    logic signed [FieldW-1:0] seg_size;
    logic signed [FieldW-1:0] applied;
    logic                     at_end;
  } cursor_result_t;

  typedef struct packed {
    logic                     is_cfg;
    logic [PtrW-1:0]          len_val;
    cmd_e                     op;
    logic [DataW-1:0]         din;
    logic signed [FieldW-1:0] off;
    origin_e                  org;
    logic                     typed;
    cursor_result_t           want;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic                     cfg_we_i;
  logic [PtrW-1:0]          cfg_wdata_i;
  logic [2:0]               cmd_i;
  logic [DataW-1:0]         data_in_i;
  logic signed [FieldW-1:0] offset_i;
  logic [1:0]               origin_i;
  logic                     done_o;
  logic [DataW-1:0]         data_out_o;
  logic                     end_hit_o;
  logic signed [FieldW-1:0] position_o;
  logic signed [FieldW-1:0] segment_size_o;
  logic signed [FieldW-1:0] applied_count_o;
  logic                     at_end_o;

  logic [DataW-1:0] byte_image [Depth];
  int               win_start;
  int               win_cursor;
  int               win_end;
  int               buf_len;
  cursor_result_t   pending [$];
  stim_row_t        dir_rows [$];
  cursor_result_t   seen;
  cursor_result_t   head;
  int               errors = 0;
  int               quiet_cycles = 0;
  bit               gaps_on = 1'b1;

  packet_buffer_cursor_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd_i),
    .data_in_i      (data_in_i),
    .offset_i       (offset_i),
    .origin_i       (origin_i),
    .done_o         (done_o),
    .data_out_o     (data_out_o),
    .end_hit_o      (end_hit_o),
    .position_o     (position_o),
    .segment_size_o (segment_size_o),
    .applied_count_o(applied_count_o),
    .at_end_o       (at_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int fit_length(logic [PtrW-1:0] v);
    if (v == 0) return 1;
    if (v > Depth) return Depth;
    return int'(v);
  endfunction

  function void rewind_image();
    win_start  = 0;
    win_cursor = 0;
    win_end    = buf_len;
  endfunction

  function automatic cursor_result_t step_window(cmd_e op, logic [DataW-1:0] din,
                                                 logic signed [FieldW-1:0] off, origin_e org);
    cursor_result_t r;
    int offv;
    int target;
    int prev;
    r = '0;
    offv = off;
    case (op)
      CMD_GET, CMD_PEEK: begin
        if (win_cursor >= win_end) begin
          r.end_hit = 1'b1;
        end else begin
          r.data = byte_image[win_cursor];
          if (op == CMD_GET) win_cursor++;
        end
      end
      CMD_NEXT: begin
        if (win_cursor >= win_end) begin
          r.end_hit = 1'b1;
        end else begin
          win_cursor++;
          if (win_cursor >= win_end) r.end_hit = 1'b1;
          else r.data = byte_image[win_cursor];
        end
      end
      CMD_SKIP: begin
        if (win_cursor >= win_end) r.end_hit = 1'b1;
        else win_cursor++;
      end
      CMD_PUT: begin
        if (win_cursor >= win_end) begin
          r.end_hit = 1'b1;
        end else begin
          byte_image[win_cursor] = din;
          r.data = din;
          win_cursor++;
        end
      end
      CMD_SEEK: begin
        if (offv == 0) begin
          if (org == ORG_START) win_cursor = win_start;
          else if (org == ORG_END) win_cursor = win_end;
        end else begin
          case (org)
            ORG_START:  target = win_start + offv;
            ORG_CURSOR: target = win_cursor + offv;
            ORG_END:    target = win_end - offv;
            default:    target = win_cursor;
          endcase
          if (target < 0) target = 0;
          if (target < win_start) win_cursor = win_start;
          else if (target > win_end) win_cursor = win_end;
          else win_cursor = target;
        end
      end
      CMD_HIDE: begin
        if (offv != 0 && org == ORG_START) begin
          prev = win_start;
          target = win_start + offv;
          if (target < 0) target = 0;
          else if (target > buf_len) target = buf_len;
          win_start  = target;
          win_cursor = target;
          r.applied  = FieldW'(target - prev);
        end else if (offv != 0 && org == ORG_END) begin
          prev = win_end;
          target = win_end - offv;
          if (target < 0) target = 0;
          else if (target > buf_len) target = buf_len;
          win_end    = target;
          win_cursor = target;
          r.applied  = FieldW'(prev - target);
        end
      end
      CMD_REWIND: rewind_image();
      default: ;
    endcase
    r.position = FieldW'(win_cursor - win_start);
    r.seg_size = FieldW'(win_end - win_start);
    r.at_end   = (win_cursor == win_end);
    return r;
  endfunction

  function automatic stim_row_t op_row(cmd_e op, logic [DataW-1:0] din,
                                       logic signed [FieldW-1:0] off, origin_e org);
    stim_row_t s;
    s = '0;
    s.op  = op;
    s.din = din;
    s.off = off;
    s.org = org;
    return s;
  endfunction

  function automatic stim_row_t chk_row(cmd_e op, logic [DataW-1:0] din,
                                        logic signed [FieldW-1:0] off, origin_e org,
                                        cursor_result_t want);
    stim_row_t s;
    s = op_row(op, din, off, org);
    s.typed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [PtrW-1:0] v);
    stim_row_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.len_val = v;
    return s;
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    errors++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic send_op(cmd_e op, logic [DataW-1:0] din, logic signed [FieldW-1:0] off,
                         origin_e org, logic typed, cursor_result_t want);
    cursor_result_t r;
    while (gaps_on && $urandom_range(99) < 25) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    cmd_i     = op;
    data_in_i = din;
    offset_i  = off;
    origin_i  = org;
    start     = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = step_window(op, din, off, org);
    pending.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  task automatic write_length(logic [PtrW-1:0] v);
    start = 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    buf_len  = fit_length(v);
    rewind_image();
  endtask

  task automatic send_random();
    int                       sel;
    int                       span;
    int                       pick;
    cmd_e                     op;
    origin_e                  org;
    logic signed [FieldW-1:0] off;
    sel = $urandom_range(99);
    if (sel < 16) op = CMD_GET;
    else if (sel < 26) op = CMD_PEEK;
    else if (sel < 38) op = CMD_NEXT;
    else if (sel < 46) op = CMD_SKIP;
    else if (sel < 66) op = CMD_PUT;
    else if (sel < 80) op = CMD_SEEK;
    else if (sel < 94) op = CMD_HIDE;
    else op = CMD_REWIND;
    span = (buf_len < 64) ? buf_len + 2 : 64;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(4))
        0: off = -14'sd4096;
        1: off = 14'sd4096;
        2: off = 14'sd1;
        3: off = -14'sd1;
        default: off = 14'sd0;
      endcase
    end else if (pick < 3) begin
      off = FieldW'(int'($urandom_range(8192)) - 4096);
    end else begin
      off = FieldW'(int'($urandom_range(2 * span)) - span);
    end
    if (op == CMD_HIDE && $urandom_range(9) < 8) org = $urandom_range(1) ? ORG_END : ORG_START;
    else org = origin_e'($urandom_range(3));
    send_op(op, DataW'($urandom()), off, org, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen = {data_out_o, end_hit_o, position_o, segment_size_o, applied_count_o, at_end_o};
      if (pending.size() == 0) begin
        flag_mismatch("unexpected result", 1, 0);
      end else begin
        head = pending.pop_front();
        if (seen.data !== head.data) flag_mismatch("data_out", seen.data, head.data);
        if (seen.end_hit !== head.end_hit) flag_mismatch("end_hit", seen.end_hit, head.end_hit);
        if (seen.position !== head.position)
          flag_mismatch("position", seen.position, head.position);
        if (seen.seg_size !== head.seg_size)
          flag_mismatch("segment_size", seen.seg_size, head.seg_size);
        if (seen.applied !== head.applied)
          flag_mismatch("applied_count", seen.applied, head.applied);
        if (seen.at_end !== head.at_end) flag_mismatch("at_end", seen.at_end, head.at_end);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("packet_buffer_cursor_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [PtrW-1:0] len;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    cmd_i       = CMD_GET;
    data_in_i   = '0;
    offset_i    = '0;
    origin_i    = ORG_START;
    foreach (byte_image[i]) byte_image[i] = '0;
    buf_len = Depth;
    rewind_image();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_rows.push_back(chk_row(CMD_PEEK, 8'h00, 14'sd0, ORG_START,
                               cursor_result_t'{8'h00, 1'b0, 14'sd0, 14'sd4096, 14'sd0, 1'b0}));
    dir_rows.push_back(cfg_row(13'd0));
    dir_rows.push_back(chk_row(CMD_PUT, 8'hFF, 14'sd0, ORG_START,
                               cursor_result_t'{8'hFF, 1'b0, 14'sd1, 14'sd1, 14'sd0, 1'b1}));
    dir_rows.push_back(chk_row(CMD_PUT, 8'h00, 14'sd0, ORG_START,
                               cursor_result_t'{8'h00, 1'b1, 14'sd1, 14'sd1, 14'sd0, 1'b1}));
    dir_rows.push_back(chk_row(CMD_SEEK, 8'h00, 14'sd0, ORG_START,
                               cursor_result_t'{8'h00, 1'b0, 14'sd0, 14'sd1, 14'sd0, 1'b0}));
    dir_rows.push_back(chk_row(CMD_PEEK, 8'h00, 14'sd0, ORG_START,
                               cursor_result_t'{8'hFF, 1'b0, 14'sd0, 14'sd1, 14'sd0, 1'b0}));
    dir_rows.push_back(op_row(CMD_NEXT, 8'h00, 14'sd0, ORG_START));
    dir_rows.push_back(op_row(CMD_SKIP, 8'h00, 14'sd0, ORG_START));
    dir_rows.push_back(op_row(CMD_GET, 8'h00, 14'sd0, ORG_START));
    dir_rows.push_back(cfg_row(13'h1FFF));
    dir_rows.push_back(chk_row(CMD_GET, 8'h00, 14'sd0, ORG_START,
                               cursor_result_t'{8'hFF, 1'b0, 14'sd1, 14'sd4096, 14'sd0, 1'b0}));
    dir_rows.push_back(op_row(CMD_SEEK, 8'h00, 14'sd4096, ORG_END));
    dir_rows.push_back(op_row(CMD_SEEK, 8'h00, -14'sd4096, ORG_START));
    dir_rows.push_back(op_row(CMD_SEEK, 8'h00, 14'sd4096, ORG_CURSOR));
    dir_rows.push_back(op_row(CMD_SEEK, 8'h00, 14'sd0, ORG_END));
    dir_rows.push_back(op_row(CMD_SEEK, 8'h00, 14'sd5, ORG_INVALID));
    dir_rows.push_back(chk_row(CMD_HIDE, 8'h00, 14'sd4096, ORG_START,
                               cursor_result_t'{8'h00, 1'b0, 14'sd0, 14'sd0, 14'sd4096, 1'b1}));
    dir_rows.push_back(chk_row(CMD_HIDE, 8'h00, 14'sd4096, ORG_END,
                               cursor_result_t'{8'h00, 1'b0, -14'sd4096, -14'sd4096,
                                                14'sd4096, 1'b1}));
    dir_rows.push_back(op_row(CMD_GET, 8'h00, 14'sd0, ORG_START));
    dir_rows.push_back(op_row(CMD_SEEK, 8'h00, 14'sd1, ORG_CURSOR));
    dir_rows.push_back(op_row(CMD_PUT, 8'h5A, 14'sd0, ORG_START));
    dir_rows.push_back(op_row(CMD_HIDE, 8'h00, -14'sd4096, ORG_START));
    dir_rows.push_back(op_row(CMD_HIDE, 8'h00, -14'sd4096, ORG_END));
    dir_rows.push_back(op_row(CMD_HIDE, 8'h00, 14'sd7, ORG_CURSOR));
    dir_rows.push_back(op_row(CMD_HIDE, 8'h00, 14'sd0, ORG_START));
    dir_rows.push_back(chk_row(CMD_REWIND, 8'h00, 14'sd0, ORG_INVALID,
                               cursor_result_t'{8'h00, 1'b0, 14'sd0, 14'sd4096, 14'sd0, 1'b0}));
    dir_rows.push_back(op_row(CMD_HIDE, 8'h00, -14'sd5, ORG_START));
    dir_rows.push_back(op_row(CMD_HIDE, 8'h00, -14'sd100, ORG_END));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_length(dir_rows[i].len_val);
      else send_op(dir_rows[i].op, dir_rows[i].din, dir_rows[i].off, dir_rows[i].org,
                   dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: len = 13'd1;
        1: len = 13'd4096;
        2: len = 13'd0;
        3: len = 13'h1FFF;
        4: len = PtrW'($urandom_range(16, 2));
        5: len = PtrW'($urandom_range(300, 17));
        6: len = PtrW'($urandom());
        7: len = PtrW'($urandom_range(64, 2));
        8: len = PtrW'($urandom_range(4096, 1));
        default: len = PtrW'($urandom_range(8, 1));
      endcase
      gaps_on = (p != 4);
      write_length(len);
      repeat (95) send_random();
    end

    start = 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("packet_buffer_cursor_top regression: pass");
    end else begin
      $display("packet_buffer_cursor_top regression: fail");
    end
    $finish;
  end

endmodule
